// ----- hdl/vmrq_pkg.sv -----
`default_nettype none

package vmrq_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_W  = 11;
    localparam int OFF_W  = 10;
    localparam int SIZE_W = 11;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    // Packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((WORD_W + OFF_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WORD_W + SIZE_W + 1 + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND = 2'd0,
        CMD_READ = 2'd1,
        CMD_FREE = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BAD     = 2'd3
    } t_status;

    // Side information of one item between the memory read and the result register
    typedef struct packed {
        t_status status;
        logic    rd_ok;
        logic    empty;
    } t_stage;

endpackage

`default_nettype wire

// ----- hdl/vmrq_ram.sv -----
`default_nettype none

module vmrq_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [AW-1:0]              i_wr_addr,
    input  wire logic [vmrq_pkg::WORD_W-1:0] i_wr_data,
    input  wire logic                       i_a_en,
    input  wire logic [AW-1:0]              i_a_addr,
    output logic      [vmrq_pkg::WORD_W-1:0] o_a_data,
    input  wire logic [AW-1:0]              i_b_addr,
    output logic      [vmrq_pkg::WORD_W-1:0] o_b_data
);
    import vmrq_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Port A: read on request, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_a_en) begin
            o_a_data <= r_mem[i_a_addr];
        end
    end

    // Port B: read every cycle, pass a same-cycle write through
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_b_addr)) begin
            o_b_data <= i_wr_data;
        end else begin
            o_b_data <= r_mem[i_b_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/variable_message_ring_queue_core.sv -----
`default_nettype none

// Mailbox of variable-length messages kept in a word ring, each message in one
// contiguous piece whose first word is its size in words. Send words arrive one
// beat at a time; a message is placed after the send point when the room there
// is strictly larger than its size, else at word 0 behind a skip mark when the
// room before the receive point is strictly larger, else it is dropped whole.
// Read returns one word of the oldest complete message, free releases it.
// Every input beat gives exactly one result beat. The block takes one beat per
// clock when not stalled; results pass the stage and result registers. The ring
// memory has one write port and two registered read ports, one of which tracks
// the size word of the oldest message on every cycle so that a free, or a read
// right after a free, finds the head size already in a register. The skip mark
// is held as a position register, not written to the ring. The ring memory has
// no reset and needs no clearing pass; writing queue_words empties the queue.
module variable_message_ring_queue_core #(
    parameter int RING_DEPTH = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration: queue_words
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [vmrq_pkg::CFG_W-1:0]     i_cfg_data,
    // input beats
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata from bit 0: message_word[31:0], read_offset[41:32], zero pad
    input  wire logic [vmrq_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: cmd[1:0]
    input  wire logic [vmrq_pkg::CMD_W-1:0]     i_s_axis_tuser,
    // result beats
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // tdata from bit 0: read_word[31:0], head_size[42:32], queue_empty[43], zero pad
    output logic      [vmrq_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: status[1:0]
    output logic      [vmrq_pkg::STAT_W-1:0]    o_m_axis_tuser
);
    import vmrq_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int PW = AW + 1;
    localparam logic [31:0] DEPTH32 = 32'(RING_DEPTH);

    // ---------------- queue state ----------------
    logic [AW-1:0]    r_send_point, n_send_point;
    logic [AW-1:0]    r_receive_point, n_receive_point;
    logic [AW-1:0]    r_fill_point, n_fill_point;
    logic [AW-1:0]    r_next_send_point, n_next_send_point;
    logic [PW-1:0]    r_words_left, n_words_left;
    logic             r_dropping, n_dropping;
    logic [CFG_W-1:0] r_queue_words, n_queue_words;
    logic [AW-1:0]    r_head_start, n_head_start;
    logic [AW-1:0]    r_skip_at, n_skip_at;
    logic             r_skip_valid, n_skip_valid;

    // ---------------- pipeline ----------------
    logic        r_s1_valid;
    t_stage      r_s1, n_s1;
    logic        r_out_valid;
    t_status     r_out_status;
    logic [WORD_W-1:0] r_out_word;
    logic [SIZE_W-1:0] r_out_head;
    logic        r_out_empty;

    // ---------------- memory ports ----------------
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_a_data;
    logic [WORD_W-1:0] rd_b_data;   // size word of the current oldest message

    logic          cfg_wr;
    logic          accept;
    logic          out_free;
    logic          s1_move;
    t_cmd          cmd;
    logic [WORD_W-1:0] in_word;
    logic [OFF_W-1:0]  in_off;

    logic [31:0]   q32;
    logic [PW-1:0] q;

    assign in_word = i_s_axis_tdata[WORD_W-1:0];
    assign in_off  = i_s_axis_tdata[WORD_W+OFF_W-1:WORD_W];
    assign cmd     = t_cmd'(i_s_axis_tuser);

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // Handshake: the result register frees the stage behind it; hold input
    // beats off while a configuration write is presented
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_move         = r_s1_valid && out_free;
    assign o_s_axis_tready = (!r_s1_valid || out_free) && !i_cfg_valid;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Ring length in use: clamp the register to [2, RING_DEPTH]
    always_comb begin
        q32 = {{(32-CFG_W){1'b0}}, r_queue_words};
        if (q32 < 32'd2) begin
            q32 = 32'd2;
        end
        if (q32 > DEPTH32) begin
            q32 = DEPTH32;
        end
        q = q32[PW-1:0];
    end

    // ---------------- step logic ----------------
    logic [PW-1:0] sp_ext, rp_ext;
    logic [PW-1:0] sz;
    logic [PW-1:0] tail_room, head_room;
    logic [PW-1:0] nsp_sum;
    logic [PW-1:0] nr_sum;
    logic [AW-1:0] nr;
    logic [AW-1:0] place;
    logic          placed;
    logic          set_skip;

    assign sp_ext = {1'b0, r_send_point};
    assign rp_ext = {1'b0, r_receive_point};
    assign sz     = in_word[PW-1:0];
    assign nr_sum = {1'b0, r_head_start} + rd_b_data[PW-1:0];
    assign nr     = (nr_sum >= q) ? '0 : nr_sum[AW-1:0];

    always_comb begin
        n_send_point      = r_send_point;
        n_receive_point   = r_receive_point;
        n_fill_point      = r_fill_point;
        n_next_send_point = r_next_send_point;
        n_words_left      = r_words_left;
        n_dropping        = r_dropping;
        n_queue_words     = r_queue_words;
        n_head_start      = r_head_start;
        n_skip_at         = r_skip_at;
        n_skip_valid      = r_skip_valid;
        wr_en             = 1'b0;
        wr_addr           = r_fill_point;
        wr_data           = in_word;
        rd_addr           = AW'(32'(r_head_start) + 32'(in_off));
        tail_room         = '0;
        head_room         = '0;
        nsp_sum           = '0;
        place             = r_send_point;
        placed            = 1'b0;
        set_skip          = 1'b0;
        n_s1.status       = ST_OK;
        n_s1.rd_ok        = 1'b0;
        n_s1.empty        = 1'b1;

        if (cfg_wr) begin
            // new ring length: drop everything, abandon a message in progress
            n_queue_words     = i_cfg_data;
            n_send_point      = '0;
            n_receive_point   = '0;
            n_fill_point      = '0;
            n_next_send_point = '0;
            n_words_left      = '0;
            n_dropping        = 1'b0;
            n_head_start      = '0;
            n_skip_valid      = 1'b0;
        end else if (accept) begin
            case (cmd)
                CMD_SEND: begin
                    if (r_words_left != '0) begin
                        // continuation word: store it or drop it
                        n_words_left = r_words_left - PW'(1);
                        if (r_dropping) begin
                            n_s1.status = ST_NO_ROOM;
                            if (n_words_left == '0) begin
                                n_dropping = 1'b0;
                            end
                        end else begin
                            wr_en        = 1'b1;
                            wr_addr      = r_fill_point;
                            n_fill_point = r_fill_point + AW'(1);
                            if (n_words_left == '0) begin
                                n_send_point = r_next_send_point;
                            end
                        end
                    end else if ((in_word == '0) || (in_word > 32'(q))) begin
                        n_s1.status = ST_BAD;
                    end else begin
                        if (sp_ext >= rp_ext) begin
                            tail_room = q - sp_ext;
                            head_room = rp_ext;
                        end else begin
                            tail_room = rp_ext - sp_ext;
                            head_room = '0;
                        end
                        if (tail_room > sz) begin
                            place   = r_send_point;
                            placed  = 1'b1;
                            nsp_sum = sp_ext + sz;
                            n_next_send_point = (nsp_sum >= q) ? '0 : nsp_sum[AW-1:0];
                        end else if (head_room > sz) begin
                            // wrap: mark the tail as skipped, place at word 0
                            place             = '0;
                            placed            = 1'b1;
                            set_skip          = 1'b1;
                            n_next_send_point = sz[AW-1:0];
                        end else begin
                            n_s1.status  = ST_NO_ROOM;
                            n_words_left = sz - PW'(1);
                            n_dropping   = (sz != PW'(1));
                        end
                        if (placed) begin
                            wr_en        = 1'b1;
                            wr_addr      = place;
                            n_fill_point = place + AW'(1);
                            n_words_left = sz - PW'(1);
                            n_dropping   = 1'b0;
                            if (sz == PW'(1)) begin
                                n_send_point = n_next_send_point;
                            end
                            // an empty queue gets this message as its head
                            if (r_send_point == r_receive_point) begin
                                n_head_start = place;
                            end
                        end
                    end
                end
                CMD_READ: begin
                    if (r_send_point == r_receive_point) begin
                        n_s1.status = ST_EMPTY;
                    end else if ({{(WORD_W-OFF_W){1'b0}}, in_off} >= rd_b_data) begin
                        n_s1.status = ST_BAD;
                    end else begin
                        n_s1.rd_ok = 1'b1;
                    end
                end
                CMD_FREE: begin
                    if (r_send_point == r_receive_point) begin
                        n_s1.status = ST_EMPTY;
                    end else begin
                        // advance past the oldest message, follow a skip mark
                        n_receive_point = nr;
                        n_head_start    = (r_skip_valid && (nr == r_skip_at)) ? '0 : nr;
                    end
                end
                default: begin
                    n_s1.status = ST_BAD;
                end
            endcase

            // a word stored over the skip position retires the mark
            if (wr_en && (wr_addr == r_skip_at)) begin
                n_skip_valid = 1'b0;
            end
            if (set_skip) begin
                n_skip_at    = r_send_point;
                n_skip_valid = 1'b1;
            end
            n_s1.empty = (n_send_point == n_receive_point);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_point      <= '0;
            r_receive_point   <= '0;
            r_fill_point      <= '0;
            r_next_send_point <= '0;
            r_words_left      <= '0;
            r_dropping        <= 1'b0;
            r_queue_words     <= CFG_W'(1024);
            r_head_start      <= '0;
            r_skip_at         <= '0;
            r_skip_valid      <= 1'b0;
        end else begin
            r_send_point      <= n_send_point;
            r_receive_point   <= n_receive_point;
            r_fill_point      <= n_fill_point;
            r_next_send_point <= n_next_send_point;
            r_words_left      <= n_words_left;
            r_dropping        <= n_dropping;
            r_queue_words     <= n_queue_words;
            r_head_start      <= n_head_start;
            r_skip_at         <= n_skip_at;
            r_skip_valid      <= n_skip_valid;
        end
    end

    // ---------------- ring memory ----------------
    vmrq_ram #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_a_en    (accept),
        .i_a_addr  (rd_addr),
        .o_a_data  (rd_a_data),
        .i_b_addr  (n_head_start),
        .o_b_data  (rd_b_data)
    );

    // ---------------- stage and result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // rd_b_data still holds the head size as left by the item in the stage
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_status <= r_s1.status;
            r_out_word   <= r_s1.rd_ok ? rd_a_data : '0;
            r_out_head   <= r_s1.empty ? '0 : rd_b_data[SIZE_W-1:0];
            r_out_empty  <= r_s1.empty;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {{(M_TDATA_W-WORD_W-SIZE_W-1){1'b0}},
                              r_out_empty, r_out_head, r_out_word};

    // ---------------- assertions ----------------
    a_points_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sp_ext < q) && (rp_ext < q))
        else $error("send or receive point outside the ring");

    a_drop_has_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> (r_words_left != '0))
        else $error("dropping with no words left");

    a_head_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_send_point != r_receive_point) |-> ({1'b0, r_head_start} < q))
        else $error("head start outside the ring");

    a_stage_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_axis_tready) |=> r_s1_valid)
        else $error("stage lost a beat while the result register was stalled");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none

module testbench;
    import vmrq_pkg::*;

    localparam int RING_DEPTH     = 1024;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int HOLD_OFF       = 4;
    localparam int NUM_PHASES     = 8;

    // tuser value with no command behind it
    localparam logic [CMD_W-1:0] CMD_ILLEGAL = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] word;
        logic [OFF_W-1:0]  offset;
    } t_beat;

    typedef struct {
        t_status           status;
        logic [WORD_W-1:0] word;
        logic [SIZE_W-1:0] head_size;
        logic              empty;
    } t_reply;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic [S_TDATA_W-1:0] s_data    = '0;
    logic [CMD_W-1:0]     s_user    = '0;
    logic                 m_ready   = 1'b0;
    wire logic                 cfg_ready;
    wire logic                 s_ready;
    wire logic                 m_valid;
    wire logic [M_TDATA_W-1:0] m_data;
    wire logic [STAT_W-1:0]    m_user;

    variable_message_ring_queue_core #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ---------------------------------------------------------------------
    // Mailbox predictor: its own copy of the ring and the pointers
    // ---------------------------------------------------------------------
    logic [WORD_W-1:0] ring_copy [RING_DEPTH];
    int unsigned queue_words_now = 1024;
    int unsigned snd_pt      = 0;
    int unsigned rcv_pt      = 0;
    int unsigned fill_pt     = 0;
    int unsigned nxt_snd_pt  = 0;
    int unsigned words_owed  = 0;
    bit          dropping    = 1'b0;

    function automatic int unsigned clamp_len(input int unsigned v);
        if (v < 2) return 2;
        if (v > RING_DEPTH) return RING_DEPTH;
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] ring_rd(input int unsigned a);
        return (a < RING_DEPTH) ? ring_copy[a] : '0;
    endfunction

    function automatic void ring_wr(input int unsigned a, input logic [WORD_W-1:0] v);
        if (a < RING_DEPTH) ring_copy[a] = v;
    endfunction

    // Follow a skip mark to the start of the oldest message
    function automatic int unsigned head_start();
        return (ring_rd(rcv_pt) == '0) ? 0 : rcv_pt;
    endfunction

    function automatic void apply_queue_words(input logic [CFG_W-1:0] v);
        queue_words_now = 32'(v);
        snd_pt     = 0;
        rcv_pt     = 0;
        fill_pt    = 0;
        nxt_snd_pt = 0;
        words_owed = 0;
        dropping   = 1'b0;
    endfunction

    function automatic t_status ring_send(input logic [WORD_W-1:0] w);
        int unsigned q;
        int unsigned tail_room;
        int unsigned head_room;
        int unsigned place;
        q = clamp_len(queue_words_now);
        // continuation word: store it, or drop it for a rejected message
        if (words_owed != 0) begin
            words_owed--;
            if (dropping) begin
                if (words_owed == 0) dropping = 1'b0;
                return ST_NO_ROOM;
            end
            ring_wr(fill_pt, w);
            fill_pt++;
            if (words_owed == 0) snd_pt = nxt_snd_pt;
            return ST_OK;
        end
        if (w == 0 || w > q) return ST_BAD;
        if (snd_pt >= rcv_pt) begin
            tail_room = q - snd_pt;
            head_room = rcv_pt;
        end else begin
            tail_room = rcv_pt - snd_pt;
            head_room = 0;
        end
        if (tail_room > w) begin
            place      = snd_pt;
            nxt_snd_pt = place + w;
            if (nxt_snd_pt >= q) nxt_snd_pt = 0;
        end else if (head_room > w) begin
            // leave a skip mark and wrap to word 0
            ring_wr(snd_pt, '0);
            place      = 0;
            nxt_snd_pt = w;
        end else begin
            words_owed = w - 1;
            dropping   = (words_owed != 0);
            return ST_NO_ROOM;
        end
        ring_wr(place, w);
        fill_pt    = place + 1;
        words_owed = w - 1;
        dropping   = 1'b0;
        if (words_owed == 0) snd_pt = nxt_snd_pt;
        return ST_OK;
    endfunction

    function automatic t_reply mailbox_step(input logic [CMD_W-1:0] cmd,
                                            input logic [WORD_W-1:0] w,
                                            input logic [OFF_W-1:0] off);
        t_reply            r;
        int unsigned       q;
        int unsigned       h;
        int unsigned       sz;
        int unsigned       nr;
        logic [WORD_W-1:0] size_word;
        r.status    = ST_OK;
        r.word      = '0;
        r.head_size = '0;
        case (cmd)
            CMD_SEND: begin
                r.status = ring_send(w);
            end
            CMD_READ, CMD_FREE: begin
                if (snd_pt == rcv_pt) begin
                    r.status = ST_EMPTY;
                end else begin
                    q  = clamp_len(queue_words_now);
                    h  = head_start();
                    sz = ring_rd(h);
                    if (cmd == CMD_READ) begin
                        if (off >= sz) r.status = ST_BAD;
                        else r.word = ring_rd(h + off);
                    end else begin
                        nr = h + sz;
                        if (nr >= q) nr = 0;
                        rcv_pt = nr;
                    end
                end
            end
            default: begin
                r.status = ST_BAD;
            end
        endcase
        r.empty = (snd_pt == rcv_pt);
        if (!r.empty) begin
            size_word   = ring_rd(head_start());
            r.head_size = size_word[SIZE_W-1:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: feed beats from the pending queue, stall the result side
    // ---------------------------------------------------------------------
    t_beat       beats_to_send [$];
    int unsigned beats_queued    = 0;
    int unsigned send_gap_pct    = 0;
    int unsigned reply_stall_pct = 0;
    t_beat       next_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_ready) begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    next_beat = beats_to_send.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= {{(S_TDATA_W-WORD_W-OFF_W){1'b0}}, next_beat.offset,
                                next_beat.word};
                    s_user  <= next_beat.cmd;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= reply_stall_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: predict on every accepted beat, check every result beat
    // ---------------------------------------------------------------------
    t_reply      replies_due [$];
    t_reply      want;
    int unsigned mismatches = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_valid && cfg_ready) apply_queue_words(cfg_data);
            if (s_valid && s_ready)
                replies_due.push_back(mailbox_step(s_user, s_data[WORD_W-1:0],
                                                   s_data[WORD_W+OFF_W-1:WORD_W]));
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat: status %0d data %h", m_user, m_data);
                end else begin
                    want = replies_due.pop_front();
                    if (m_user !== want.status || m_data[31:0] !== want.word ||
                        m_data[42:32] !== want.head_size || m_data[43] !== want.empty) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result mismatch (expected/actual): status %0d/%0d ",
                                      "word %h/%h head_size %0d/%0d empty %0b/%0b"},
                                     want.status, m_user, want.word, m_data[31:0],
                                     want.head_size, m_data[42:32], want.empty, m_data[43]);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ---------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    task automatic queue_beat(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] w,
                              input int unsigned off);
        t_beat b;
        b.cmd    = cmd;
        b.word   = w;
        b.offset = OFF_W'(off);
        beats_to_send.push_back(b);
        beats_queued++;
    endtask

    function automatic int unsigned pick_offset();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(7);
        if (r < 90) return $urandom_range(63);
        return $urandom_range(1023);
    endfunction

    // Size word, then random content; now and then slip a read or free in
    task automatic queue_message(input int unsigned sz);
        queue_beat(CMD_SEND, sz, $urandom_range(1023));
        for (int unsigned k = 1; k < sz; k++) begin
            if ($urandom_range(99) < 10)
                queue_beat(($urandom_range(1) != 0) ? CMD_READ : CMD_FREE, $urandom(),
                           pick_offset());
            queue_beat(CMD_SEND, $urandom(), $urandom_range(1023));
        end
    endtask

    task automatic queue_traffic(input int unsigned q, input int unsigned n);
        int unsigned first;
        int unsigned r;
        int unsigned sz;
        first = beats_queued;
        while (beats_queued - first < n) begin
            r = $urandom_range(99);
            if (r < 45) begin
                r = $urandom_range(99);
                if (r < 80) sz = $urandom_range(1, (q < 8) ? q : 8);
                else if (r < 98) sz = $urandom_range(1, (q < 64) ? q : 64);
                else sz = $urandom_range(1, q);
                queue_message(sz);
            end else if (r < 70) begin
                queue_beat(CMD_READ, $urandom(), pick_offset());
            end else if (r < 90) begin
                queue_beat(CMD_FREE, $urandom(), $urandom_range(1023));
            end else begin
                // noise: bad size words and the command with no meaning
                case ($urandom_range(2))
                    0: queue_beat(CMD_SEND, '0, $urandom_range(1023));
                    1: queue_beat(CMD_SEND, q + 1 + $urandom_range(3000), $urandom_range(1023));
                    default: queue_beat(CMD_ILLEGAL, $urandom(), $urandom_range(1023));
                endcase
            end
        end
    endtask

    task automatic set_idle(input t_idle_mode mode);
        send_gap_pct    = (mode == IDLE_SENDER)   ? 84 : (mode == IDLE_BOTH) ? 8 : 0;
        reply_stall_pct = (mode == IDLE_RECEIVER) ? 84 : (mode == IDLE_BOTH) ? 8 : 0;
    endtask

    // Hold until every beat is sent and answered, then let the pipeline settle
    task automatic drain();
        while (beats_to_send.size() != 0 || s_valid || replies_due.size() != 0)
            @(negedge i_clk);
        repeat (HOLD_OFF) @(negedge i_clk);
    endtask

    task automatic write_queue_words(input int unsigned v);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(v);
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        static int unsigned phase_cfg   [NUM_PHASES] = '{16, 0, 37, 2047, 5, 1024, 3, 2};
        static int unsigned phase_beats [NUM_PHASES] = '{300, 150, 250, 200, 200, 200, 150,
                                                         120};
        static t_idle_mode  phase_idle  [NUM_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
                                                         IDLE_BOTH, IDLE_NONE, IDLE_RECEIVER,
                                                         IDLE_SENDER, IDLE_BOTH};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset size ring: empty queue, bad commands and sizes, two short messages,
        // offsets at the edge, a read while a message is still arriving
        set_idle(IDLE_NONE);
        queue_beat(CMD_READ, '0, '0);
        queue_beat(CMD_FREE, '0, '0);
        queue_beat(CMD_ILLEGAL, '1, '1);
        queue_beat(CMD_SEND, '0, '0);
        queue_beat(CMD_SEND, '1, '1);
        queue_beat(CMD_SEND, 1, '0);
        queue_beat(CMD_READ, '0, '0);
        queue_beat(CMD_READ, '0, '1);
        queue_beat(CMD_SEND, 3, '0);
        queue_beat(CMD_READ, '0, '0);
        queue_beat(CMD_SEND, '1, '1);
        queue_beat(CMD_SEND, '0, '0);
        queue_beat(CMD_FREE, '0, '0);
        queue_beat(CMD_READ, '1, 2);
        queue_beat(CMD_FREE, '0, '0);
        drain();

        // Four-word ring: no room with dropped words, then a wrap behind a skip mark
        write_queue_words(4);
        queue_message(2);
        queue_beat(CMD_SEND, 2, '0);
        queue_beat(CMD_SEND, 32'h5a5a_a5a5, '0);
        queue_beat(CMD_FREE, '0, '0);
        queue_beat(CMD_SEND, 1, '0);
        queue_beat(CMD_FREE, '0, '0);
        queue_beat(CMD_SEND, 2, '0);
        queue_beat(CMD_SEND, 32'hc3c3_3c3c, '0);
        queue_beat(CMD_READ, '0, 1);
        queue_beat(CMD_FREE, '0, '0);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_queue_words(phase_cfg[p]);
            set_idle(phase_idle[p]);
            queue_traffic(clamp_len(phase_cfg[p]), phase_beats[p]);
            drain();
        end

        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/vmrq_pkg.sv
hdl/vmrq_ram.sv
hdl/variable_message_ring_queue_core.sv
test/testbench.sv
